### hw/rtl/mrtu_pkg.sv
package mrtu_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_RX    = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RD     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;

  localparam logic [7:0] FC_READ   = 8'h03;
  localparam logic [7:0] FC_WRITE1 = 8'h06;
  localparam logic [7:0] FC_WRITEN = 8'h10;

  localparam logic [9:0] ERR_UNSUP  = 10'h001;
  localparam logic [9:0] ERR_TXTO   = 10'h002;
  localparam logic [9:0] ERR_RXTO   = 10'h004;
  localparam logic [9:0] ERR_ADDR   = 10'h008;
  localparam logic [9:0] ERR_FUNC   = 10'h010;
  localparam logic [9:0] ERR_BCNT   = 10'h020;
  localparam logic [9:0] ERR_CRC    = 10'h040;
  localparam logic [9:0] ERR_REGA   = 10'h080;
  localparam logic [9:0] ERR_VALUE  = 10'h100;
  localparam logic [9:0] ERR_COUNT  = 10'h200;

  localparam logic [0:0] CFG_TX_TO = 1'b0;
  localparam logic [0:0] CFG_RX_TO = 1'b1;

  localparam logic [12:0] TX_TO_RST = 13'd100;
  localparam logic [12:0] RX_TO_RST = 13'd200;
  localparam logic [12:0] TICK_CAP  = 13'd5000;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

endpackage

### hw/rtl/modbus_rtu_master_transaction.sv
// Modbus RTU master for function codes 3, 6 and 16. Every input beat is taken
// only while the sequencer is idle; a received byte passes through a receive
// state, and a start emits its request frame (8 to 7+2*count+2 bytes) at one
// byte per cycle while the output is free, pausing after each written word for
// the word store's registered read. After a successful read reply, each word
// passes through a read state and an emit state before the status beat. All
// byte CRC updates go through one shared CRC-16 unit. The output register lets
// the next input beat be taken while the last result waits on the master side.
module modbus_rtu_master_transaction
  import mrtu_pkg::*;
#(
  parameter int MAX_REGS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slave_address, function_code, first_register, register_count,
  // word_slot, word_value, rx_byte, tx_drained
  input  logic [71:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_data, error_flags
  output logic [31:0] m_axis_tdata,
  // out_kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  localparam int WDepth = (MAX_REGS > 16) ? MAX_REGS : 16;
  localparam int WAw    = $clog2(WDepth);
  localparam int RAw    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int Cw     = $clog2(MAX_REGS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TX   = 3'd1;
  localparam logic [2:0] ST_TXW  = 3'd2;
  localparam logic [2:0] ST_RX   = 3'd3;
  localparam logic [2:0] ST_RDA  = 3'd4;
  localparam logic [2:0] ST_RDE  = 3'd5;
  localparam logic [2:0] ST_STAT = 3'd6;

  logic [2:0]  st_q, st_d;
  logic [1:0]  ph_q, ph_d;
  logic [12:0] cnt_q, cnt_d, txto_q, rxto_q;
  logic [9:0]  err_q, err_d;
  logic [7:0]  slv_q, slv_d, fn_q, fn_d, pend_q, pend_d, rxb_q, rxb_d;
  logic [15:0] fr_q, fr_d, crc_q, crc_d;
  logic [4:0]  num_q, num_d;
  logic [5:0]  pos_q, pos_d, idx_q, idx_d;
  logic [Cw-1:0] wp_q, wp_d, rp_q, rp_d;

  logic        ovld_q, olast_q;
  logic [1:0]  okind_q;
  logic [15:0] odata_q;
  logic [9:0]  oerr_q;

  logic        emit, e_last, ofree, s_fire;
  logic [1:0]  e_kind;
  logic [15:0] e_data;
  logic [9:0]  e_err;
  logic        ww_we, rw_we;
  logic [RAw-1:0] rw_addr;
  logic [15:0] ww_rd, rw_rd;
  logic [7:0]  crc_byte;
  logic [15:0] crc_nx;

  logic [7:0]  in_slv, in_fn, in_rx;
  logic [15:0] in_fr, in_val;
  logic [4:0]  in_num;
  logic [3:0]  in_slot;
  logic        in_drn;

  assign in_slv  = s_axis_tdata[7:0];
  assign in_fn   = s_axis_tdata[15:8];
  assign in_fr   = s_axis_tdata[31:16];
  assign in_num  = s_axis_tdata[36:32];
  assign in_slot = s_axis_tdata[40:37];
  assign in_val  = s_axis_tdata[56:41];
  assign in_rx   = s_axis_tdata[64:57];
  assign in_drn  = s_axis_tdata[65];

  assign s_axis_tready = (st_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign ofree         = !ovld_q || m_axis_tready;

  mrtu_ram #(.Width(16), .Depth(WDepth)) u_wwords (
    .clk_i   (clk_i),
    .we_i    (ww_we),
    .waddr_i (WAw'(in_slot)),
    .wdata_i (in_val),
    .raddr_i (WAw'(wp_q)),
    .rdata_o (ww_rd)
  );

  mrtu_ram #(.Width(16), .Depth(MAX_REGS)) u_rwords (
    .clk_i   (clk_i),
    .we_i    (rw_we),
    .waddr_i (rw_addr),
    .wdata_i ({pend_q, rxb_q}),
    .raddr_i (RAw'(rp_q)),
    .rdata_o (rw_rd)
  );

  mrtu_crc u_crc (
    .crc_i  (crc_q),
    .data_i (crc_byte),
    .crc_o  (crc_nx)
  );

  always_comb begin
    logic [5:0]  nbody, crc_at, pm3;
    logic [7:0]  txb;
    logic [9:0]  e;
    logic [12:0] c;
    logic [1:0]  ph;
    logic        is_crc, fn3;
    logic [15:0] w;

    st_d = st_q; ph_d = ph_q; cnt_d = cnt_q; err_d = err_q;
    slv_d = slv_q; fn_d = fn_q; fr_d = fr_q; num_d = num_q;
    pend_d = pend_q; rxb_d = rxb_q; crc_d = crc_q;
    pos_d = pos_q; idx_d = idx_q; wp_d = wp_q; rp_d = rp_q;
    emit = 1'b0; e_kind = KIND_TX; e_data = 16'h0; e_last = 1'b0; e_err = 10'h0;
    ww_we = 1'b0; rw_we = 1'b0;
    e = 10'h0; c = cnt_q; ph = ph_q; is_crc = 1'b0;

    fn3    = (fn_q == FC_READ);
    nbody  = (fn_q == FC_WRITEN) ? 6'd7 + {num_q, 1'b0} : 6'd6;
    crc_at = fn3 ? 6'd3 + {num_q, 1'b0} : 6'd6;
    pm3    = pos_q - 6'd3;
    rw_addr = RAw'(pm3[5:1]);
    w      = {pend_q, rxb_q};

    if (idx_q == 6'd0)      txb = slv_q;
    else if (idx_q == 6'd1) txb = fn_q;
    else if (idx_q == 6'd2) txb = fr_q[15:8];
    else if (idx_q == 6'd3) txb = fr_q[7:0];
    else if (idx_q == 6'd4) txb = (fn_q == FC_WRITE1) ? ww_rd[15:8] : 8'h00;
    else if (idx_q == 6'd5) txb = (fn_q == FC_WRITE1) ? ww_rd[7:0] : {3'b000, num_q};
    else if (idx_q < nbody) txb = (idx_q == 6'd6) ? {2'b00, num_q, 1'b0}
                                  : (idx_q[0] ? ww_rd[15:8] : ww_rd[7:0]);
    else if (idx_q == nbody) txb = crc_q[7:0];
    else                     txb = crc_q[15:8];

    crc_byte = (st_q == ST_RX) ? rxb_q : txb;

    case (st_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (s_axis_tuser)
            REQ_START: begin
              if (ph_q == PH_IDLE) begin
                slv_d = in_slv; fn_d = in_fn; fr_d = in_fr;
                num_d = (in_num > 5'(MAX_REGS)) ? 5'(MAX_REGS) : in_num;
                if (in_fn != FC_READ && in_fn != FC_WRITE1 && in_fn != FC_WRITEN) begin
                  err_d = ERR_UNSUP;
                  st_d  = ST_STAT;
                end else begin
                  err_d = 10'h0;
                  idx_d = 6'd0; wp_d = '0; crc_d = CRC_INIT;
                  st_d  = ST_TX;
                end
              end
            end
            REQ_LOAD: ww_we = 1'b1;
            REQ_RX: begin
              if (ph_q == PH_WAIT) begin
                rxb_d = in_rx;
                st_d  = ST_RX;
              end
            end
            REQ_TICK: begin
              ph = ph_q; c = cnt_q; e = err_q;
              if (ph == PH_SEND) begin
                if (in_drn) begin
                  ph = PH_WAIT; c = 13'd0;
                end
                if (ph == PH_SEND && c > txto_q) e = e | ERR_TXTO;
              end else if (ph == PH_WAIT) begin
                if (c > rxto_q) e = e | ERR_RXTO;
              end
              if (c < TICK_CAP) c = c + 13'd1;
              if (ph != PH_IDLE && e != 10'h0) begin
                ph = PH_IDLE;
                st_d = ST_STAT;
              end
              ph_d = ph; cnt_d = c; err_d = e;
            end
            default: ;
          endcase
        end
      end
      ST_TX: begin
        if (ofree) begin
          emit = 1'b1; e_kind = KIND_TX; e_data = {8'h00, txb};
          idx_d = idx_q + 6'd1;
          if (idx_q < nbody) crc_d = crc_nx;
          if (fn_q == FC_WRITEN && idx_q >= 6'd7 && idx_q < nbody && !idx_q[0]) begin
            wp_d = wp_q + Cw'(1);
            st_d = ST_TXW;
          end
          if (idx_q == nbody + 6'd1) begin
            e_last = 1'b1;
            ph_d = PH_SEND; cnt_d = 13'd0; pos_d = 6'd0;
            crc_d = CRC_INIT; pend_d = 8'h00; wp_d = '0;
            st_d = ST_IDLE;
          end
        end
      end
      ST_TXW: st_d = ST_TX;
      ST_RX: begin
        e = 10'h0; is_crc = 1'b0;
        if (pos_q == crc_at) begin
          is_crc = 1'b1;
          if (rxb_q != crc_q[7:0]) e = ERR_CRC;
        end else if (pos_q == crc_at + 6'd1) begin
          is_crc = 1'b1;
          if (rxb_q != crc_q[15:8]) e = ERR_CRC;
        end else if (pos_q == 6'd0) begin
          if (rxb_q != slv_q) e = ERR_ADDR;
        end else if (pos_q == 6'd1) begin
          if (rxb_q != fn_q) e = ERR_FUNC;
        end else if (fn3) begin
          if (pos_q == 6'd2) begin
            if (rxb_q != {2'b00, num_q, 1'b0}) e = ERR_BCNT;
          end else if (!pm3[0]) begin
            pend_d = rxb_q;
          end else begin
            rw_we = 1'b1;
          end
        end else begin
          if (pos_q == 6'd2 || pos_q == 6'd4) begin
            pend_d = rxb_q;
          end else if (pos_q == 6'd3) begin
            if (w != fr_q) e = ERR_REGA;
          end else if (fn_q == FC_WRITE1) begin
            if (w != ww_rd) e = ERR_VALUE;
          end else begin
            if (w != {11'h0, num_q}) e = ERR_COUNT;
          end
        end
        if (!is_crc) crc_d = crc_nx;
        pos_d = pos_q + 6'd1;
        if (e != 10'h0) begin
          err_d = err_q | e;
          ph_d  = PH_IDLE;
          st_d  = ST_STAT;
        end else if (pos_q == crc_at + 6'd1) begin
          ph_d = PH_IDLE;
          rp_d = '0;
          st_d = (fn3 && num_q != 5'd0) ? ST_RDA : ST_STAT;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_RDA: st_d = ST_RDE;
      ST_RDE: begin
        if (ofree) begin
          emit = 1'b1; e_kind = KIND_RD; e_data = rw_rd;
          rp_d = rp_q + Cw'(1);
          st_d = (5'(rp_q) + 5'd1 == num_q) ? ST_STAT : ST_RDA;
        end
      end
      ST_STAT: begin
        if (ofree) begin
          emit = 1'b1; e_kind = KIND_STATUS; e_data = 16'h0;
          e_err = err_q; e_last = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      ph_q   <= PH_IDLE;
      cnt_q  <= 13'd0;
      err_q  <= 10'h0;
      slv_q  <= 8'h00;
      fn_q   <= 8'h00;
      fr_q   <= 16'h0;
      num_q  <= 5'd0;
      pend_q <= 8'h00;
      crc_q  <= CRC_INIT;
      pos_q  <= 6'd0;
      idx_q  <= 6'd0;
      wp_q   <= '0;
      rp_q   <= '0;
      txto_q <= TX_TO_RST;
      rxto_q <= RX_TO_RST;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
      slv_q  <= slv_d;
      fn_q   <= fn_d;
      fr_q   <= fr_d;
      num_q  <= num_d;
      pend_q <= pend_d;
      crc_q  <= crc_d;
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TX_TO) txto_q <= cfg_data_i;
        else                        rxto_q <= cfg_data_i;
      end
      if (emit)               ovld_q <= 1'b1;
      else if (m_axis_tready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rxb_q <= rxb_d;
    if (emit) begin
      okind_q <= e_kind;
      odata_q <= e_data;
      olast_q <= e_last;
      oerr_q  <= e_err;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'b000000, oerr_q, odata_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

endmodule

### hw/rtl/mrtu_ram.sv
module mrtu_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/mrtu_crc.sv
module mrtu_crc
  import mrtu_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_o = c;
  end

endmodule
